>>> rtl/core/bjet_pkg.sv
// Shared types, constants and fixed-point helpers for the biquadratic escape-time unit.
package bjet_pkg;

    localparam int FRAC_BITS   = 22;
    localparam int COORD_WIDTH = 32;
    localparam int PARAM_WIDTH = 27;
    localparam int PARAM_FRAC  = 22;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = PARAM_WIDTH;

    // Internal values: sign plus MAG_W magnitude bits, saturating at +-LIM.
    localparam int MAG_W  = FRAC_BITS + 8;
    localparam int VAL_W  = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SUM_W  = VAL_W + 2;
    localparam int CMP_W  = (COORD_WIDTH > MAG_W) ? COORD_WIDTH : MAG_W;
    localparam int PAR_W  = PARAM_WIDTH + MAG_W;
    localparam int P_SHL  = (FRAC_BITS >= PARAM_FRAC) ? FRAC_BITS - PARAM_FRAC : 0;
    localparam int P_SHR  = (PARAM_FRAC > FRAC_BITS) ? PARAM_FRAC - FRAC_BITS : 0;
    localparam int SQ_SHIFT    = FRAC_BITS;
    localparam int CROSS_SHIFT = FRAC_BITS - 1;

    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [PROD_W-1:0]       prod_t;

    localparam mag_t LIM = '1;
    localparam logic signed [SUM_W-1:0] LIM_S = {3'b000, LIM};
    localparam logic [MAG_W:0] TEN = (MAG_W + 1)'(10) << FRAC_BITS;

    localparam logic [PARAM_WIDTH-1:0] PARAM_A_RESET = PARAM_WIDTH'(0);
    localparam logic [PARAM_WIDTH-1:0] PARAM_B_RESET = PARAM_WIDTH'(4194304);
    localparam logic [COUNT_W-1:0]     MAX_ITER_RESET = COUNT_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARAM_A  = 2'd0,
        CFG_PARAM_B  = 2'd1,
        CFG_MAX_ITER = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_CHECK,
        ST_MUL1,
        ST_HALF_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic half_a;
        logic half_b;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic stop;
    } dp_status_t;

    function automatic val_t to_val(input logic neg, input mag_t mm);
        val_t v;
        v = val_t'({1'b0, mm});
        return neg ? -v : v;
    endfunction

    function automatic mag_t mag_of(input val_t v);
        val_t n;
        n = -v;
        return v[VAL_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // Product magnitude shifted right (toward zero), saturated to LIM.
    function automatic mag_t scale_prod(input prod_t p, input int unsigned sh);
        prod_t q;
        q = p >> sh;
        return (q > PROD_W'(LIM)) ? LIM : q[MAG_W-1:0];
    endfunction

    function automatic val_t sat_sum(input logic signed [SUM_W-1:0] s);
        val_t r;
        if (s > LIM_S) begin
            r = val_t'({1'b0, LIM});
        end else if (s < -LIM_S) begin
            r = -val_t'({1'b0, LIM});
        end else begin
            r = s[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic val_t load_coord(input logic [COORD_WIDTH-1:0] x);
        logic                   neg;
        logic [COORD_WIDTH-1:0] m;
        logic [CMP_W-1:0]       w;
        neg = x[COORD_WIDTH-1];
        m   = neg ? (~x + COORD_WIDTH'(1)) : x;
        w   = CMP_W'(m);
        if (w > CMP_W'(LIM)) begin
            w = CMP_W'(LIM);
        end
        return to_val(neg, w[MAG_W-1:0]);
    endfunction

    function automatic val_t load_param(input logic [PARAM_WIDTH-1:0] x);
        logic                   neg;
        logic [PARAM_WIDTH-1:0] m;
        logic [PAR_W-1:0]       w;
        neg = x[PARAM_WIDTH-1];
        m   = neg ? (~x + PARAM_WIDTH'(1)) : x;
        w   = (PAR_W'(m) << P_SHL) >> P_SHR;
        if (w > PAR_W'(LIM)) begin
            w = PAR_W'(LIM);
        end
        return to_val(neg, w[MAG_W-1:0]);
    endfunction

endpackage

>>> rtl/core/bjet_ctrl.sv
// Sequencer for the escape-time loop and the result handshake.
module bjet_ctrl
    import bjet_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_CHECK;
            ST_CHECK:  state_next = status.stop ? ST_FINISH : ST_MUL1;
            ST_MUL1:   state_next = ST_HALF_B;
            ST_HALF_B: state_next = ST_MUL0;
            ST_FINISH: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL0, ST_MUL1: cmd.mul = 1'b1;
            ST_CHECK:  cmd.half_a = !status.stop;
            ST_HALF_B: cmd.half_b = 1'b1;
            ST_FINISH: cmd.out_load = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> rtl/core/bjet_dp.sv
// Datapath: config registers, point registers, three multipliers, update and escape test.
module bjet_dp
    import bjet_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [COORD_WIDTH-1:0] start_real,
    input  logic [COORD_WIDTH-1:0] start_imag,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic [COUNT_W-1:0]     iteration_count,
    output logic                   escaped
);

    logic [PARAM_WIDTH-1:0] param_a_reg, param_b_reg;
    logic [COUNT_W-1:0]     max_iter_reg;

    val_t               a_val_reg, b_val_reg;
    val_t               re_reg, im_reg;
    prod_t              p_rr_reg, p_ii_reg, p_ri_reg;
    logic               neg_ri_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_esc_reg;

    mag_t                    re_mag, im_mag;
    mag_t                    re2, im2, ri_mag;
    val_t                    ri_val, re_next;
    logic [MAG_W:0]          mag_sum;
    logic signed [SUM_W-1:0] upd_sum;
    val_t                    add_const;
    logic                    below_max;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            param_a_reg  <= PARAM_A_RESET;
            param_b_reg  <= PARAM_B_RESET;
            max_iter_reg <= MAX_ITER_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_PARAM_A:  param_a_reg  <= cfg_wr_data[PARAM_WIDTH-1:0];
                CFG_PARAM_B:  param_b_reg  <= cfg_wr_data[PARAM_WIDTH-1:0];
                CFG_MAX_ITER: max_iter_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign re_mag = mag_of(re_reg);
    assign im_mag = mag_of(im_reg);

    // Squares and the doubled cross term of the current point.
    assign re2    = scale_prod(p_rr_reg, SQ_SHIFT);
    assign im2    = scale_prod(p_ii_reg, SQ_SHIFT);
    assign ri_mag = scale_prod(p_ri_reg, CROSS_SHIFT);
    assign ri_val = to_val(neg_ri_reg, ri_mag);

    assign mag_sum   = {1'b0, re2} + {1'b0, im2};
    assign below_max = count_reg < max_iter_reg;
    assign status.stop = (mag_sum >= TEN) || !below_max;

    assign add_const = cmd.half_a ? a_val_reg : b_val_reg;
    assign upd_sum   = SUM_W'($signed({2'b00, re2})) - SUM_W'($signed({2'b00, im2}))
                     + SUM_W'(add_const);
    assign re_next   = sat_sum(upd_sum);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            re_reg    <= load_coord(start_real);
            im_reg    <= load_coord(start_imag);
            a_val_reg <= load_param(param_a_reg);
            b_val_reg <= load_param(param_b_reg);
            count_reg <= '0;
        end else begin
            if (cmd.half_a || cmd.half_b) begin
                re_reg <= re_next;
                im_reg <= ri_val;
            end
            if (cmd.half_b) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
        if (cmd.mul) begin
            p_rr_reg   <= PROD_W'(re_mag) * PROD_W'(re_mag);
            p_ii_reg   <= PROD_W'(im_mag) * PROD_W'(im_mag);
            p_ri_reg   <= PROD_W'(re_mag) * PROD_W'(im_mag);
            neg_ri_reg <= re_reg[VAL_W-1] ^ im_reg[VAL_W-1];
        end
        if (cmd.out_load) begin
            out_count_reg <= count_reg;
            out_esc_reg   <= below_max;
        end
    end

    assign iteration_count = out_count_reg;
    assign escaped         = out_esc_reg;

endmodule

>>> rtl/core/biquadratic_julia_escape_time_unit.sv
// Top level of the biquadratic escape-time unit: stream ports, config port, sequencer, datapath.
// Escape-time engine for z -> (z^2+a)^2+b on signed Q10.22 points. One point is worked at a
// time: a transfer on the s_ side loads it (inputs beyond +-256 are clamped), then each step
// of the map is two half-steps, each formed by a multiply state in the three parallel
// 30x30 multipliers (re^2, im^2, re*im) and a state of scale, saturate and add. The
// magnitude test re^2+im^2 < 10 rides on the first half of each step. s_tready is
// high while idle and a finished result may still wait in the output register for m_tready
// while the next point is taken. Config writes (param_a, param_b, max_iterations) must only
// happen while the unit is idle with no result pending; param_a and param_b are sampled at
// the input transfer.
module biquadratic_julia_escape_time_unit
    import bjet_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input points
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // [31:0] start_real, [63:32] start_imag
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [15:0] iteration_count
    output logic [0:0]             m_tuser    // [0] escaped
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       escaped;

    bjet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bjet_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .start_real      (s_tdata[COORD_WIDTH-1:0]),
        .start_imag      (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .cmd             (cmd),
        .status          (status),
        .iteration_count (m_tdata),
        .escaped         (escaped)
    );

    assign m_tuser = escaped;

endmodule

>>> rtl/core/bjet_chk.sv
// Port-level checker for the escape-time unit, bound to the top level.
module bjet_chk
    import bjet_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input logic [CFG_DATA_W-1:0] cfg_wr_data,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [15:0]           m_tdata,
    input logic [0:0]            m_tuser
);

    logic [COUNT_W-1:0] max_shadow_reg, max_shadow_next;

    always_comb begin
        max_shadow_next = max_shadow_reg;
        if (cfg_wr_en && cfg_wr_index == CFG_MAX_ITER) begin
            max_shadow_next = cfg_wr_data[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_shadow_reg <= MAX_ITER_RESET;
        end else begin
            max_shadow_reg <= max_shadow_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one point at a time
    a_one_point: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a point is in flight");

    a_escaped_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata < max_shadow_reg)
        else $error("escaped result at or above the limit");

    a_bounded_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == max_shadow_reg)
        else $error("bounded result count differs from the limit");

endmodule

bind biquadratic_julia_escape_time_unit bjet_chk u_chk (.*);

>>> test/testbench.sv
// Self-checking testbench for the biquadratic escape-time unit.
module testbench;
    import bjet_pkg::*;

    localparam int      CLK_HALF   = 5;
    localparam int      RESET_CYC  = 5;
    // Generous run limit for the slowest legal run.
    localparam longint  RUN_LIMIT  = 64'd50_000_000;
    localparam int      PHASE_ITEMS = 75;
    localparam int      PHASES      = 12;

    // Fixed-point limits of the datapath: values saturate just below 256.0.
    localparam longint  SAT_MAX    = (64'sd1 <<< (FRAC_BITS + 8)) - 1;
    localparam longint  ESCAPE_R2  = 64'sd10 <<< FRAC_BITS;

    localparam logic [PARAM_WIDTH-1:0] PARAM_MIN = {1'b1, {(PARAM_WIDTH-1){1'b0}}};
    localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = {1'b0, {(PARAM_WIDTH-1){1'b1}}};
    localparam logic [PARAM_WIDTH-1:0] ONE_Q22   = PARAM_WIDTH'(1 << FRAC_BITS);
    // Index 3 maps to no register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               escaped;
    } escape_t;

    // Tracks register contents, predicts each point's escape time and checks results.
    class escape_scoreboard;
        logic [PARAM_WIDTH-1:0] reg_a;
        logic [PARAM_WIDTH-1:0] reg_b;
        logic [COUNT_W-1:0]     reg_limit;
        escape_t                expected_escapes[$];
        int                     failures;

        function void reset_regs();
            reg_a     = '0;
            reg_b     = ONE_Q22;
            reg_limit = 16'd50;
            failures  = 0;
        endfunction

        function void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PARAM_A:  reg_a = data;
                CFG_PARAM_B:  reg_b = data;
                CFG_MAX_ITER: reg_limit = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        static function longint clamp(longint v);
            if (v > SAT_MAX) return SAT_MAX;
            if (v < -SAT_MAX) return -SAT_MAX;
            return v;
        endfunction

        // Exact product, magnitude shifted toward zero, then saturated.
        static function longint scaled_product(longint x, longint y, int sh);
            longint          mx;
            longint          my;
            longint unsigned p;
            longint          r;
            bit              neg;
            neg = (x < 0) != (y < 0);
            mx  = (x < 0) ? -x : x;
            my  = (y < 0) ? -y : y;
            p   = mx * my;
            r   = longint'(p >> sh);
            if (r > SAT_MAX) r = SAT_MAX;
            return neg ? -r : r;
        endfunction

        function escape_t escape_of(logic [COORD_WIDTH-1:0] re_in,
                                    logic [COORD_WIDTH-1:0] im_in,
                                    logic [COUNT_W-1:0] limit);
            longint      re;
            longint      im;
            longint      a;
            longint      b;
            longint      re2;
            longint      im2;
            int unsigned steps;
            escape_t     r;
            re    = clamp(longint'($signed(re_in)));
            im    = clamp(longint'($signed(im_in)));
            a     = longint'($signed(reg_a));
            b     = longint'($signed(reg_b));
            re2   = scaled_product(re, re, FRAC_BITS);
            im2   = scaled_product(im, im, FRAC_BITS);
            steps = 0;
            while (steps < limit && (re2 + im2) < ESCAPE_R2) begin
                // first half: z^2 + a
                im  = scaled_product(re, im, FRAC_BITS - 1);
                re  = clamp(re2 - im2 + a);
                re2 = scaled_product(re, re, FRAC_BITS);
                im2 = scaled_product(im, im, FRAC_BITS);
                // second half: w^2 + b
                im  = scaled_product(re, im, FRAC_BITS - 1);
                re  = clamp(re2 - im2 + b);
                re2 = scaled_product(re, re, FRAC_BITS);
                im2 = scaled_product(im, im, FRAC_BITS);
                steps++;
            end
            r.count   = steps[COUNT_W-1:0];
            r.escaped = (steps < limit);
            return r;
        endfunction

        function void note_point(logic [COORD_WIDTH-1:0] re_in, logic [COORD_WIDTH-1:0] im_in);
            expected_escapes.push_back(escape_of(re_in, im_in, reg_limit));
        endfunction

        function void check_result(logic [COUNT_W-1:0] count, logic escaped);
            escape_t e;
            if (expected_escapes.size() == 0) begin
                $error("unexpected result: iteration_count %0d escaped %0d", count, escaped);
                failures++;
                return;
            end
            e = expected_escapes.pop_front();
            if (count !== e.count) begin
                $error("iteration_count: expected %0d, actual %0d", e.count, count);
                failures++;
            end
            if (escaped !== e.escaped) begin
                $error("escaped: expected %0d, actual %0d", e.escaped, escaped);
                failures++;
            end
        endfunction

        function int pending();
            return expected_escapes.size();
        endfunction
    endclass

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata      = '0;   // [31:0] start_real, [63:32] start_imag
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [15:0]            m_tdata;             // [15:0] iteration_count
    logic [0:0]             m_tuser;             // [0] escaped

    escape_scoreboard sb;

    // Idle controls, set per phase by the stimulus process.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_len = 0;   // one-shot long back-pressure request

    always #(CLK_HALF) aclk = ~aclk;

    biquadratic_julia_escape_time_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // One config write; the enable drops for a cycle afterwards so back-to-back
    // writes never raise and lower it in the same step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        sb.store_reg(idx, data);
        cfg_wr_en    <= 1'b0;
        @(posedge aclk);
    endtask

    // Upper bits of the limit write carry junk; only the low 16 bits count.
    task automatic configure(input logic [PARAM_WIDTH-1:0] a, input logic [PARAM_WIDTH-1:0] b,
                             input logic [COUNT_W-1:0] limit);
        cfg_write(CFG_PARAM_A, a);
        cfg_write(CFG_PARAM_B, b);
        cfg_write(CFG_MAX_ITER, {11'($urandom), limit});
    endtask

    // Offer one point and hold it until the transfer; valid stays up unless a gap follows.
    task automatic send_point(input logic [31:0] re, input logic [31:0] im);
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_point(re, im);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};   // garbage while idle
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly points within +-2.0 where orbits live; some full-range and boundary values.
    function automatic logic [31:0] random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        if (pick < 85) return $urandom;
        case ($urandom_range(0, 8))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h3fff_ffff;   // exactly the saturation limit
            4: return 32'hc000_0001;
            5: return 32'h4000_0000;   // one past the limit, clamped on entry
            6: return 32'hc000_0000;
            7: return 32'h0000_0001;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [PARAM_WIDTH-1:0] random_param();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) return PARAM_WIDTH'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        if (pick < 90) return PARAM_WIDTH'($urandom);
        if (pick < 95) return PARAM_MIN;
        return PARAM_MAX;
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    // Result side: checks every transfer, then decides m_tready for the next cycle.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if (rx_hold_len > 0) begin
                stall_left  = rx_hold_len;
                rx_hold_len = 0;
            end else if (stall_left == 0 && $urandom_range(99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        escape_t                probe;
        int                     ph;
        logic [PARAM_WIDTH-1:0] a_val;
        logic [PARAM_WIDTH-1:0] b_val;
        logic [COUNT_W-1:0]     limit;
        logic [31:0]            mag;

        sb = new();
        sb.reset_regs();
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: reset config, field extremes ----
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h0000_0001, 32'hffff_ffff);
        send_point(32'hffff_ffff, 32'h0000_0000);
        send_point(32'h0040_0000, 32'h0000_0000);   // 1.0
        send_point(32'h0000_0000, 32'h0020_0000);   // 0.5i
        send_point(32'h3fff_ffff, 32'hc000_0001);
        send_point(32'h4000_0000, 32'hbfff_ffff);
        drain();

        // Escape landing exactly on the limit reports bounded; one more step reports escape.
        probe = sb.escape_of(32'h0, 32'h0, 16'hffff);
        cfg_write(CFG_MAX_ITER, CFG_DATA_W'(probe.count));
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0010_0000, 32'h0008_0000);
        drain();
        cfg_write(CFG_MAX_ITER, CFG_DATA_W'(probe.count + 16'd1));
        send_point(32'h0000_0000, 32'h0000_0000);
        drain();

        // Zero limit: no step is applied at all.
        cfg_write(CFG_MAX_ITER, '0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000);
        drain();

        // A write to the unused index must leave every register alone.
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write(CFG_MAX_ITER, CFG_DATA_W'(20));
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0020_0000, 32'h0030_0000);
        drain();

        // ---- largest limit: origin never moves with a = b = 0, so it runs all 65535 steps ----
        configure('0, '0, 16'hffff);
        send_point(32'h0000_0000, 32'h0000_0000);
        repeat (4) begin
            // far outside the escape radius, so these finish at once
            mag = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
            send_point($urandom_range(0, 1) ? -mag : mag, random_coord());
        end
        drain();

        // ---- random phases ----
        for (ph = 0; ph < PHASES; ph++) begin
            a_val = random_param();
            b_val = random_param();
            limit = COUNT_W'($urandom_range(1, 64));
            case (ph)
                0: begin a_val = PARAM_MIN; b_val = PARAM_MAX; end
                1: begin a_val = PARAM_MAX; b_val = PARAM_MIN; end
                2: limit = 16'd1;
                3: begin a_val = '0; b_val = '0; limit = 16'd200; end
                4: limit = COUNT_W'($urandom_range(65, 200));
                default: ;
            endcase
            // the closing phases run with no idling on either side
            tx_idle_pct = (ph >= PHASES - 2) ? 0 : pick_idle();
            rx_idle_pct = (ph >= PHASES - 2) ? 0 : pick_idle();
            configure(a_val, b_val, limit);
            // back-pressure long enough to fill the unit and stall its input
            if (ph == 5) rx_hold_len = 3000;
            repeat (PHASE_ITEMS) send_point(random_coord(), random_coord());
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bjet_pkg.sv
rtl/core/bjet_ctrl.sv
rtl/core/bjet_dp.sv
rtl/core/biquadratic_julia_escape_time_unit.sv
rtl/core/bjet_chk.sv
test/testbench.sv
